// ===== rtl/core/gce_pkg.sv =====
// Shared types and constants of the gradient curve evaluator.
// Holds field widths, command and register codes, controller states and the
// command and status bundles between controller and datapath. No dependencies.
package gce_pkg;

   localparam int CMD_W       = 2;
   localparam int INDEX_W     = 3;
   localparam int TIME_W      = 17;
   localparam int COLOR_W     = 32;
   localparam int SCALE_W     = 16;
   localparam int MS_W        = 32;
   localparam int WIDTH_W     = 32;
   localparam int NODES_W     = 4;
   localparam int INV_W       = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_NODES_IN_USE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_LIFE     = 1'b1;

   localparam logic [INV_W-1:0]  INV_LIFE_RESET = 32'd4294967;
   localparam logic [TIME_W-1:0] FRAC_ONE       = 17'h10000;

   localparam int STEP_W    = 4;
   localparam int LANE_W    = 3;
   localparam logic [STEP_W-1:0] DIV_LAST   = 4'd15;
   localparam logic [LANE_W-1:0] LANE_SCALE = 3'd4;

   typedef struct packed {
      logic [TIME_W-1:0]  node_time;
      logic [COLOR_W-1:0] node_color;
      logic [SCALE_W-1:0] node_scale;
   } node_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] node_index;
      logic [TIME_W-1:0]  node_time;
      logic [COLOR_W-1:0] node_color;
      logic [SCALE_W-1:0] node_scale;
      logic [MS_W-1:0]    now_ms;
      logic [MS_W-1:0]    born_ms;
      logic [WIDTH_W-1:0] width_in;
   } req_data_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_FRAC,
      S_HI,
      S_WALK,
      S_ONE,
      S_DIV_SETUP,
      S_DIV,
      S_LANE,
      S_WMUL,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_MUL,
      OP_FRAC,
      OP_HI,
      OP_WALK,
      OP_ONE,
      OP_DIV_SETUP,
      OP_DIV_STEP,
      OP_LANE,
      OP_WMUL,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [LANE_W-1:0] lane;
   } dp_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic n_one;
      logic walk_done;
      logic div_skip;
   } dp_status_type;

endpackage

// ===== rtl/core/gce_if.sv =====
// Request and response channel interfaces of the gradient curve evaluator.
// Each carries valid, ready and the item fields; depends on gce_pkg.
interface gce_req_if;
   import gce_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [INDEX_W-1:0] node_index;
   logic [TIME_W-1:0]  node_time;
   logic [COLOR_W-1:0] node_color;
   logic [SCALE_W-1:0] node_scale;
   logic [MS_W-1:0]    now_ms;
   logic [MS_W-1:0]    born_ms;
   logic [WIDTH_W-1:0] width_in;

   modport source (
      output valid, cmd, node_index, node_time, node_color, node_scale,
             now_ms, born_ms, width_in,
      input  ready
   );

   modport sink (
      input  valid, cmd, node_index, node_time, node_color, node_scale,
             now_ms, born_ms, width_in,
      output ready
   );
endinterface

interface gce_rsp_if;
   import gce_pkg::*;

   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] color_out;
   logic               color_valid;
   logic [WIDTH_W-1:0] width_out;

   modport source (
      output valid, color_out, color_valid, width_out,
      input  ready
   );

   modport sink (
      input  valid, color_out, color_valid, width_out,
      output ready
   );
endinterface

// ===== rtl/core/gce_datapath.sv =====
// Datapath of the gradient curve evaluator: configuration registers, node
// memory, segment cursor, divider, interpolation lanes and result register.
// Driven by gce_ctrl through dp_cmd_type; depends on gce_pkg.
module gce_datapath #(
   parameter int MAX_NODES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gce_pkg::dp_cmd_type                  cmd,
   output gce_pkg::dp_status_type               status,
   input  gce_pkg::req_data_type                req_data,
   input  logic                                 csr_we,
   input  logic [gce_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gce_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic [gce_pkg::COLOR_W-1:0]          color_out,
   output logic                                 color_valid,
   output logic [gce_pkg::WIDTH_W-1:0]          width_out
);
   import gce_pkg::*;

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int CMP_W = (CNT_W > NODES_W) ? CNT_W : NODES_W;

   logic [NODES_W-1:0] nodes_ff, nodes_in;
   logic [INV_W-1:0]   inv_ff, inv_in;
   logic [IDX_W-1:0]   cursor_ff, cursor_in;

   logic [MS_W-1:0]    age_ff, age_in;
   logic [WIDTH_W-1:0] w_ff, w_in;
   logic [63:0]        prod_ff, prod_in;
   logic [TIME_W-1:0]  frac_ff, frac_in;
   logic [IDX_W-1:0]   c_ff, c_in;
   node_type           hi_ff, hi_in;
   node_type           lo_ff, lo_in;
   node_type           rd_data_ff;
   logic [TIME_W-1:0]  rem_ff, rem_in;
   logic [TIME_W-1:0]  d_ff, d_in;
   logic [15:0]        qs_ff, qs_in;
   logic [TIME_W-1:0]  s_ff, s_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [31:0]        scale_ff, scale_in;
   logic [63:0]        wprod_ff, wprod_in;
   logic [COLOR_W-1:0] color_out_ff, color_out_in;
   logic               color_valid_ff, color_valid_in;
   logic [WIDTH_W-1:0] width_out_ff, width_out_in;

   node_type           node_mem [MAX_NODES];
   logic               mem_we;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr;
   logic               load_in_range;

   logic [CMP_W-1:0]   nodes_ext;
   logic [CNT_W-1:0]   n_used;
   logic               multi;
   logic [IDX_W-1:0]   last_seg;
   logic [IDX_W-1:0]   c_clamp;

   logic [48:0]        frac_sum;
   logic [TIME_W-1:0]  t0, t1, seg_d;
   logic               seg_live, seg_sat;
   logic [TIME_W:0]    div_trial;
   logic               div_fit;

   logic [TIME_W-1:0]  rs;
   logic [SCALE_W-1:0] lane_a, lane_b;
   logic [32:0]        lane_pa, lane_pb;
   logic [33:0]        lane_sum;
   logic [33:0]        lane_round;
   logic [40:0]        wround;

   assign nodes_ext = CMP_W'(nodes_ff);
   assign n_used    = (nodes_ext > CMP_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(nodes_ext);
   assign multi     = n_used >= CNT_W'(2);
   assign last_seg  = IDX_W'(n_used - CNT_W'(2));
   assign c_clamp   = (cursor_ff > last_seg) ? last_seg : cursor_ff;

   assign load_in_range = 32'(req_data.node_index) < MAX_NODES;
   assign wr_addr       = IDX_W'(req_data.node_index);

   assign frac_sum = {1'b0, prod_ff[63:16]} + 49'(prod_ff[15]);

   assign t0       = lo_ff.node_time;
   assign t1       = hi_ff.node_time;
   assign seg_d    = t1 - t0;
   assign seg_live = (t1 > t0) && (frac_ff > t0);
   assign seg_sat  = frac_ff >= t1;

   assign div_trial = {rem_ff, qs_ff[15]};
   assign div_fit   = div_trial >= {1'b0, d_ff};

   assign rs       = FRAC_ONE - s_ff;
   assign lane_a   = cmd.lane[2] ? lo_ff.node_scale
                                 : {8'h00, lo_ff.node_color[{cmd.lane[1:0], 3'b000} +: 8]};
   assign lane_b   = cmd.lane[2] ? hi_ff.node_scale
                                 : {8'h00, hi_ff.node_color[{cmd.lane[1:0], 3'b000} +: 8]};
   assign lane_pa  = 33'(lane_a) * 33'(rs);
   assign lane_pb  = 33'(lane_b) * 33'(s_ff);
   assign lane_sum = {1'b0, lane_pa} + {1'b0, lane_pb};
   assign lane_round = lane_sum + 34'd32768;

   assign wround = {1'b0, wprod_ff[63:24]} + 41'(wprod_ff[23]);

   assign status.n_zero    = n_used == '0;
   assign status.n_one     = n_used == CNT_W'(1);
   assign status.walk_done = (c_ff == '0) ||
                             ((frac_ff >= rd_data_ff.node_time) && (frac_ff <= hi_ff.node_time));
   assign status.div_skip  = !seg_live || seg_sat;

   always_comb begin
      nodes_in       = nodes_ff;
      inv_in         = inv_ff;
      cursor_in      = cursor_ff;
      age_in         = age_ff;
      w_in           = w_ff;
      prod_in        = prod_ff;
      frac_in        = frac_ff;
      c_in           = c_ff;
      hi_in          = hi_ff;
      lo_in          = lo_ff;
      rem_in         = rem_ff;
      d_in           = d_ff;
      qs_in          = qs_ff;
      s_in           = s_ff;
      color_in       = color_ff;
      scale_in       = scale_ff;
      wprod_in       = wprod_ff;
      color_out_in   = color_out_ff;
      color_valid_in = color_valid_ff;
      width_out_in   = width_out_ff;
      mem_we         = 1'b0;
      rd_addr        = c_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_NODES_IN_USE: nodes_in = csr_wdata[NODES_W-1:0];
            CSR_INV_LIFE:     inv_in   = csr_wdata[INV_W-1:0];
         endcase
      end

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_ACCEPT: begin
            age_in = req_data.now_ms - req_data.born_ms;
            w_in   = req_data.width_in;
            if (req_data.cmd == CMD_LOAD) begin
               mem_we = load_in_range;
            end
            if (req_data.cmd == CMD_BEGIN) begin
               cursor_in = multi ? last_seg : '0;
            end
         end
         OP_MUL: begin
            prod_in = 64'(inv_ff) * 64'(age_ff);
         end
         OP_FRAC: begin
            frac_in = (frac_sum > 49'(FRAC_ONE)) ? FRAC_ONE : frac_sum[TIME_W-1:0];
            c_in    = multi ? c_clamp : '0;
            rd_addr = multi ? IDX_W'(c_clamp + IDX_W'(1)) : '0;
         end
         OP_HI: begin
            hi_in   = rd_data_ff;
            rd_addr = c_ff;
         end
         OP_WALK: begin
            rd_addr = IDX_W'(c_ff - IDX_W'(1));
            if (status.walk_done) begin
               lo_in     = rd_data_ff;
               cursor_in = c_ff;
            end else begin
               hi_in = rd_data_ff;
               c_in  = IDX_W'(c_ff - IDX_W'(1));
            end
         end
         OP_ONE: begin
            lo_in = rd_data_ff;
            hi_in = rd_data_ff;
         end
         OP_DIV_SETUP: begin
            rem_in = frac_ff - t0;
            d_in   = seg_d;
            qs_in  = seg_d[TIME_W-1:1];
            s_in   = (seg_live && seg_sat) ? FRAC_ONE : '0;
         end
         OP_DIV_STEP: begin
            rem_in = div_fit ? TIME_W'(div_trial - {1'b0, d_ff}) : div_trial[TIME_W-1:0];
            qs_in  = {qs_ff[14:0], div_fit};
            s_in   = {1'b0, qs_ff[14:0], div_fit};
         end
         OP_LANE: begin
            if (cmd.lane[2]) begin
               scale_in = lane_sum[31:0];
            end else begin
               color_in[{cmd.lane[1:0], 3'b000} +: 8] = lane_round[23:16];
            end
         end
         OP_WMUL: begin
            wprod_in = 64'(w_ff) * 64'(scale_ff);
         end
         OP_RESULT: begin
            if (status.n_zero) begin
               color_out_in   = '0;
               color_valid_in = 1'b0;
               width_out_in   = w_ff;
            end else begin
               color_out_in   = color_ff;
               color_valid_in = 1'b1;
               width_out_in   = (|wround[40:32]) ? '1 : wround[31:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_ff  <= '0;
         inv_ff    <= INV_LIFE_RESET;
         cursor_ff <= '0;
      end else begin
         nodes_ff  <= nodes_in;
         inv_ff    <= inv_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      age_ff         <= age_in;
      w_ff           <= w_in;
      prod_ff        <= prod_in;
      frac_ff        <= frac_in;
      c_ff           <= c_in;
      hi_ff          <= hi_in;
      lo_ff          <= lo_in;
      rem_ff         <= rem_in;
      d_ff           <= d_in;
      qs_ff          <= qs_in;
      s_ff           <= s_in;
      color_ff       <= color_in;
      scale_ff       <= scale_in;
      wprod_ff       <= wprod_in;
      color_out_ff   <= color_out_in;
      color_valid_ff <= color_valid_in;
      width_out_ff   <= width_out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[wr_addr] <= '{node_time:  req_data.node_time,
                                node_color: req_data.node_color,
                                node_scale: req_data.node_scale};
      end
      rd_data_ff <= node_mem[rd_addr];
   end

   assign color_out   = color_out_ff;
   assign color_valid = color_valid_ff;
   assign width_out   = width_out_ff;

endmodule

// ===== rtl/core/gce_ctrl.sv =====
// Controller of the gradient curve evaluator: sequences accept, age multiply,
// segment walk, division, interpolation lanes and result hand-off.
// Drives gce_datapath through dp_cmd_type; depends on gce_pkg.
module gce_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [gce_pkg::CMD_W-1:0]   req_cmd,
   output logic                        req_ready,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   input  gce_pkg::dp_status_type      status,
   output gce_pkg::dp_cmd_type         cmd
);
   import gce_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_load;

   assign out_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_cmd == CMD_EVAL) begin
               state_in = status.n_zero ? S_DONE : S_MUL;
            end
         end
         S_MUL:  state_in = S_FRAC;
         S_FRAC: state_in = status.n_one ? S_ONE : S_HI;
         S_HI:   state_in = S_WALK;
         S_WALK: begin
            if (status.walk_done) begin
               state_in = S_DIV_SETUP;
            end
         end
         S_ONE:  state_in = S_DIV_SETUP;
         S_DIV_SETUP: begin
            cnt_in   = '0;
            state_in = status.div_skip ? S_LANE : S_DIV;
         end
         S_DIV: begin
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = S_LANE;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         S_LANE: begin
            if (cnt_ff[LANE_W-1:0] == LANE_SCALE) begin
               state_in = S_WMUL;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         S_WMUL: state_in = S_DONE;
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.lane  = cnt_ff[LANE_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.op    = req_valid ? OP_ACCEPT : OP_NONE;
         end
         S_MUL:       cmd.op = OP_MUL;
         S_FRAC:      cmd.op = OP_FRAC;
         S_HI:        cmd.op = OP_HI;
         S_WALK:      cmd.op = OP_WALK;
         S_ONE:       cmd.op = OP_ONE;
         S_DIV_SETUP: cmd.op = OP_DIV_SETUP;
         S_DIV:       cmd.op = OP_DIV_STEP;
         S_LANE:      cmd.op = OP_LANE;
         S_WMUL:      cmd.op = OP_WMUL;
         S_DONE:      cmd.op = out_load ? OP_RESULT : OP_NONE;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/gradient_curve_evaluator_unit.sv =====
// Gradient curve evaluator: piecewise linear interpolation of color and width
// scale over a table of up to MAX_NODES curve nodes. Load node, begin pass and
// unused codes are taken in the idle state. An evaluate item holds the block
// until its result is loaded. On a table of two or more nodes the cursor walks
// down the segments (one node memory read per step) and a radix-2 divider
// forms the in-segment fraction; the divider is skipped when the fraction is
// 0 or 1. On any non-empty table the shared multiply-add lane then blends the
// four color channels and the scale in turn. A finished result waits in the
// output register while the next item is taken. Depends on gce_pkg, gce_if,
// gce_ctrl and gce_datapath.
module gradient_curve_evaluator_unit #(
   parameter int MAX_NODES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gce_req_if.sink                              req_bus,
   gce_rsp_if.source                            rsp_bus,
   input  logic                                 csr_we,
   input  logic [gce_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gce_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import gce_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   req_data_type  req_data;

   assign req_data = '{cmd:        req_bus.cmd,
                       node_index: req_bus.node_index,
                       node_time:  req_bus.node_time,
                       node_color: req_bus.node_color,
                       node_scale: req_bus.node_scale,
                       now_ms:     req_bus.now_ms,
                       born_ms:    req_bus.born_ms,
                       width_in:   req_bus.width_in};

   gce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (req_bus.cmd),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   gce_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .status      (dp_status),
      .req_data    (req_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .color_out   (rsp_bus.color_out),
      .color_valid (rsp_bus.color_valid),
      .width_out   (rsp_bus.width_out)
   );

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(dp_cmd.op == OP_RESULT))
      else $error("result valid rose without a result load");

   assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_RESULT) |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("result load over a stalled item");

   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.cmd == CMD_EVAL) |=> !req_bus.ready)
      else $error("request taken while an evaluation is in flight");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.color_valid) |-> (rsp_bus.color_out == '0))
      else $error("color present on an empty-table result");
`endif

endmodule
